[hw/rtl/nde_pkg.sv]
// Shared types, constants and the digit remap table for the Nixie digit encoder.
// Used by every module of the block; depends on nothing else.
package nde_pkg;

    localparam int VALUE_W = 24;            // width of an input value
    localparam int WORD_W  = 24;            // width of the word sent to the tubes
    localparam int NIB_MAX = 8;             // most digits the converter supports
    localparam int FULL_W  = 4 * NIB_MAX;   // width of the staging word in the front

    // Reciprocal of ten, exact for every dividend below 2^32.
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // One request between front, queue and back.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_word_req;

    // Largest number that n decimal places can show.
    function automatic longint unsigned f_limit(input int n);
        longint unsigned lim;
        lim = 64'd1;
        for (int i = 0; i < n; i++) begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

    // Board wiring fix: decimal digit to the code that lights that digit.
    function automatic logic [3:0] f_digit_code(input logic [3:0] d);
        logic [3:0] code;
        unique case (d)
            4'd0:    code = 4'd8;
            4'd1:    code = 4'd5;
            4'd2:    code = 4'd4;
            4'd3:    code = 4'd3;
            4'd4:    code = 4'd2;
            4'd5:    code = 4'd1;
            4'd6:    code = 4'd6;
            4'd7:    code = 4'd7;
            4'd8:    code = 4'd0;
            4'd9:    code = 4'd9;
            default: code = 4'd8;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/nixie_digit_encoder_shifter_core.sv]
// Top level of the Nixie digit encoder and bit shifter.
// Instantiates nde_front, nde_queue and nde_back; uses nde_pkg.
//
// Input channel: i_valid / o_stall with i_value. A value above the largest
// number DIGITS places can show is displayed as zero.
// Output channel: o_valid / i_stall. Each value yields min(4*DIGITS, 24)
// requests, one serial bit each (o_shift_bit, LSB of the packed word first),
// with o_last_bit high on the final bit, the point to latch the tubes.
// o_tube_word carries the whole packed word of remapped codes on every bit.
//
// Timing: the front converts one decimal digit per cycle with a reciprocal
// multiplier; the packed word then enters the two-entry queue and is loaded
// from there into the serializer, whose register drives the first bit.
// Throughput: one bit per cycle from the serializer while the receiver never
// stalls; a new word loads as the last bit of the old one leaves the serializer.
// The converter works ahead while the serializer shifts, buffered by the queue.
// When the receiver stalls, the current bit holds and the queue fills; the
// input stalls while a value converts and while its word waits for queue space.
// Reset empties the queue and returns both halves to idle; no request is shown.
module nixie_digit_encoder_shifter_core #(
    parameter int DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [nde_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_shift_bit,
    output logic                         o_last_bit,
    output logic [nde_pkg::WORD_W-1:0]   o_tube_word
);

    nde_pkg::t_word_req w_push;
    nde_pkg::t_word_req w_head;
    logic               w_full;
    logic               w_pop;

    nde_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    nde_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    nde_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_shift_bit (o_shift_bit),
        .o_last_bit  (o_last_bit),
        .o_tube_word (o_tube_word)
    );

endmodule

[hw/rtl/nde_front.sv]
// Front end: takes a value (zero if out of range), converts it to remapped digit
// codes, one decimal digit per cycle, then hands the packed word on. Uses nde_pkg.
module nde_front #(
    parameter int DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [nde_pkg::VALUE_W-1:0]  i_value,
    output nde_pkg::t_word_req           o_push,
    input  logic                         i_full
);

    localparam longint unsigned LIMIT = nde_pkg::f_limit(DIGITS);
    localparam int CNT_W  = $clog2(DIGITS + 1);
    localparam int ALIGN  = nde_pkg::FULL_W - 4 * DIGITS;
    localparam int PROD_W = nde_pkg::VALUE_W + 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [nde_pkg::VALUE_W-1:0]   r_val, n_val;
    logic [nde_pkg::FULL_W-1:0]    r_word, n_word;

    logic [PROD_W-1:0]             w_prod;
    logic [nde_pkg::VALUE_W-1:0]   w_quot;
    logic [nde_pkg::VALUE_W-1:0]   w_rem;
    logic [nde_pkg::FULL_W-1:0]    w_aligned;
    logic                          w_accept;

    // Quotient by reciprocal multiply; the remainder is value minus ten times it.
    assign w_prod = PROD_W'(r_val) * PROD_W'(nde_pkg::RECIP_TEN);
    assign w_quot = nde_pkg::VALUE_W'(w_prod[PROD_W-1:nde_pkg::RECIP_SHIFT]);
    assign w_rem  = r_val - (w_quot << 3) - (w_quot << 1);

    // Codes enter at the top, so after DIGITS steps the low digit sits lowest.
    assign w_aligned = r_word >> ALIGN;

    assign o_stall  = !((r_state == S_IDLE) || ((r_state == S_PUSH) && !i_full));
    assign w_accept = i_valid && !o_stall;

    assign o_push.valid = (r_state == S_PUSH);
    assign o_push.word  = w_aligned[nde_pkg::WORD_W-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_val   = r_val;
        n_word  = r_word;
        if (w_accept) begin
            n_state = S_CONV;
            n_cnt   = '0;
            n_val   = (64'(i_value) > LIMIT) ? '0 : i_value;
            n_word  = '0;
        end else begin
            unique case (r_state)
                S_CONV: begin
                    n_word = {nde_pkg::f_digit_code(w_rem[3:0]),
                              r_word[nde_pkg::FULL_W-1:4]};
                    n_val  = w_quot;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIGITS - 1)) begin
                        n_state = S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        n_state = S_IDLE;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_word <= n_word;
    end

endmodule

[hw/rtl/nde_queue.sv]
// Short queue of packed words between the converter and the serializer.
// Uses the request type from nde_pkg.
module nde_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nde_pkg::t_word_req  i_push,
    output logic                o_full,
    output nde_pkg::t_word_req  o_head,
    input  logic                i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [nde_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]           r_wptr, r_rptr;
    logic [CNT_W-1:0]           r_count;
    logic                       w_do_push, w_do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rptr];

    assign w_do_push = i_push.valid && !o_full;
    assign w_do_pop  = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (w_do_push) begin
            r_mem[r_wptr] <= i_push.word;
        end
    end

endmodule

[hw/rtl/nde_back.sv]
// Back end: shifts a packed word out one bit per request, LSB first, and
// marks the final bit of the run. Uses nde_pkg.
module nde_back #(
    parameter int DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nde_pkg::t_word_req           i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_shift_bit,
    output logic                         o_last_bit,
    output logic [nde_pkg::WORD_W-1:0]   o_tube_word
);

    localparam int NBITS = (4 * DIGITS > nde_pkg::WORD_W) ? nde_pkg::WORD_W : 4 * DIGITS;
    localparam int CNT_W = $clog2(NBITS);

    logic                         r_active;
    logic [CNT_W-1:0]             r_cnt;
    logic [nde_pkg::WORD_W-1:0]   r_sh;
    logic [nde_pkg::WORD_W-1:0]   r_tube;
    logic                         w_take, w_last;

    assign w_last = (r_cnt == CNT_W'(NBITS - 1));
    assign w_take = r_active && !i_stall;
    // A new word may load in the same cycle the last bit of the old one leaves.
    assign o_pop  = !r_active || (w_take && w_last);

    assign o_valid     = r_active;
    assign o_shift_bit = r_sh[0];
    assign o_last_bit  = w_last;
    assign o_tube_word = r_tube;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (o_pop) begin
            r_active <= i_head.valid;
            r_cnt    <= '0;
        end else if (w_take) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (o_pop) begin
            r_sh   <= i_head.word;
            r_tube <= i_head.word;
        end else if (w_take) begin
            r_sh <= r_sh >> 1;
        end
    end

endmodule
